// File: rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/scba_pkg.sv
// Package for the size class bitmap allocator: field widths, codes, states
// and the class geometry functions. No dependencies.
`timescale 1ns / 1ps

package scba_pkg;

    localparam int PAGE_BITS_DEF      = 16;
    localparam int MIN_CLASS_BITS_DEF = 6;
    localparam int MAX_CLASS_BITS_DEF = 12;

    localparam int REQ_W        = 16;
    localparam int OBJ_ADDR_W   = 19;
    localparam int STATUS_W     = 3;
    localparam int SIZE_CLASS_W = 3;
    localparam int FREE_CNT_W   = 11;

    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_INVALID   = 3'd1,
        STAT_TOO_LARGE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_BAD_ADDR  = 3'd4,
        STAT_DOUBLE    = 3'd5
    } scba_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_ASET,
        ST_FCHK,
        ST_OUT
    } scba_state_t;

    // slots in the page of class c; zero when the object exceeds a page
    function automatic int slots_of(int c, int page_bits, int min_bits);
        int bits;
        bits = min_bits + c;
        if (bits > page_bits)
            return 0;
        return 1 << (page_bits - bits);
    endfunction

    function automatic int words_of(int c, int page_bits, int min_bits);
        return (slots_of(c, page_bits, min_bits) + WORD_BITS - 1) >> WORD_SHIFT;
    endfunction

    // first bitmap word of class c (elaboration only)
    function automatic int base_word(int c, int page_bits, int min_bits);
        int base;
        base = 0;
        for (int i = 0; i < c; i++)
            base += words_of(i, page_bits, min_bits);
        return base;
    endfunction

endpackage

// File: rtl/size_class_bitmap_allocator.sv
// Size class bitmap allocator top level: sequencer, bitmap RAM, free counts.
// Depends on scba_pkg and assert_macros.svh.
//
//  channel | direction | handshake           | beat contents
//  --------+-----------+---------------------+-------------------------------------------
//  in      | into      | in_valid / in_stall | op, request_size, request_align, free_address
//  out     | out of    | out_valid/out_stall | status, object_address, size_class,
//          |           |                     | class_free_count
//
// An allocate passes ST_DECODE, ST_SCAN, ST_ASET and ST_OUT; ST_SCAN reads the class's
// bitmap words in turn (up to 16 for class 0 at default geometry) from the single-port
// bitmap RAM, whose read data is registered. A free passes ST_DECODE, ST_FCHK and ST_OUT;
// a rejected request goes from ST_DECODE to ST_OUT. Reset clears the per-word valid bits
// and reloads the free counts at once; no clearing pass. A stalled output holds only the
// finished result: the next input beat is still taken, and that item waits in ST_OUT.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module size_class_bitmap_allocator #(
    parameter int PAGE_BITS      = scba_pkg::PAGE_BITS_DEF,
    parameter int MIN_CLASS_BITS = scba_pkg::MIN_CLASS_BITS_DEF,
    parameter int MAX_CLASS_BITS = scba_pkg::MAX_CLASS_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic [scba_pkg::REQ_W-1:0]           request_size,
    input  logic [scba_pkg::REQ_W-1:0]           request_align,
    input  logic [scba_pkg::OBJ_ADDR_W-1:0]      free_address,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [scba_pkg::STATUS_W-1:0]        status,
    output logic [scba_pkg::OBJ_ADDR_W-1:0]      object_address,
    output logic [scba_pkg::SIZE_CLASS_W-1:0]    size_class,
    output logic [scba_pkg::FREE_CNT_W-1:0]      class_free_count
);

    // ------------------------------------------------------------------
    // Geometry
    // ------------------------------------------------------------------
    localparam int NUM_CLASSES = MAX_CLASS_BITS - MIN_CLASS_BITS + 1;
    localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int WORDS0      = scba_pkg::words_of(0, PAGE_BITS, MIN_CLASS_BITS);
    localparam int TOTAL_WORDS = scba_pkg::base_word(NUM_CLASSES, PAGE_BITS,
                                                     MIN_CLASS_BITS);
    localparam int MEM_AW      = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WIDX_W      = $clog2(WORDS0 + 1);
    localparam int CNT_W       = PAGE_BITS - MIN_CLASS_BITS + 1;
    localparam int ADDR_W      = PAGE_BITS + CLS_W;
    localparam int LOG_W       = $clog2(scba_pkg::REQ_W + 1);
    localparam int FA_W        = scba_pkg::OBJ_ADDR_W;
    localparam int WB          = scba_pkg::WORD_BITS;

    localparam logic [FA_W-1:0] PAGE_MASK = FA_W'((longint'(1) << PAGE_BITS) - 1);
    localparam logic [WIDX_W-1:0] WIDX_ONE = WIDX_W'(1);

    // per-class constant tables
    logic [MEM_AW-1:0] base_tab  [NUM_CLASSES];
    logic [WIDX_W-1:0] nw_tab    [NUM_CLASSES];
    logic [CNT_W-1:0]  slots_tab [NUM_CLASSES];

    for (genvar gc = 0; gc < NUM_CLASSES; gc++) begin : g_tab
        assign base_tab[gc]  = MEM_AW'(scba_pkg::base_word(gc, PAGE_BITS, MIN_CLASS_BITS));
        assign nw_tab[gc]    = WIDX_W'(scba_pkg::words_of(gc, PAGE_BITS, MIN_CLASS_BITS));
        assign slots_tab[gc] = CNT_W'(scba_pkg::slots_of(gc, PAGE_BITS, MIN_CLASS_BITS));
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    scba_pkg::scba_state_t state_reg, state_next;

    logic                      op_reg,    op_next;
    logic [scba_pkg::REQ_W-1:0] size_reg,  size_next;
    logic [scba_pkg::REQ_W-1:0] align_reg, align_next;
    logic [FA_W-1:0]           faddr_reg, faddr_next;
    logic [CLS_W-1:0]          cls_reg,   cls_next;
    logic [WIDX_W-1:0]         issue_w_reg, issue_w_next;
    logic [WIDX_W-1:0]         pend_w_reg,  pend_w_next;
    logic                      pend_reg,    pend_next;
    logic [WIDX_W-1:0]         hit_w_reg,   hit_w_next;
    logic [WB-1:0]             word_reg,    word_next;
    logic [WB-1:0]             onehot_reg,  onehot_next;
    logic [MEM_AW-1:0]         idx_reg,     idx_next;
    logic [5:0]                bit_reg,     bit_next;

    scba_pkg::scba_status_t    res_status_reg, res_status_next;
    logic [FA_W-1:0]           res_addr_reg,   res_addr_next;
    logic [CLS_W-1:0]          res_cls_reg,    res_cls_next;
    logic [CNT_W-1:0]          res_cnt_reg,    res_cnt_next;

    scba_pkg::scba_status_t            out_status_reg;
    logic [FA_W-1:0]                   out_addr_reg;
    logic [scba_pkg::SIZE_CLASS_W-1:0] out_cls_reg;
    logic [scba_pkg::FREE_CNT_W-1:0]   out_cnt_reg;
    logic                              out_valid_reg;
    logic                              out_load;

    // free counts, one per class, reset to the class slot count
    logic [CNT_W-1:0] cnt_reg [NUM_CLASSES];
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wdata;

    // bitmap RAM: one port, read data registered; unwritten words read as zero
    logic [WB-1:0]     mem [TOTAL_WORDS];
    logic              word_valid_reg [TOTAL_WORDS];
    logic [WB-1:0]     rd_data_reg;
    logic              rd_valid_reg;
    logic              mem_re;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [WB-1:0]     mem_wdata;

    // ------------------------------------------------------------------
    // Request decode (used in ST_DECODE)
    // ------------------------------------------------------------------
    logic [scba_pkg::REQ_W-1:0] req_max;
    logic [scba_pkg::REQ_W-1:0] req_max_m1;
    logic [LOG_W-1:0]           ceil_bits;
    logic                       req_invalid;
    logic                       too_large;
    logic [CLS_W-1:0]           alloc_cls;

    logic [FA_W-1:0]  fcls_full;
    logic             fcls_ok;
    logic [CLS_W-1:0] fcls;
    logic [FA_W-1:0]  foff;
    logic [FA_W-1:0]  fslot;
    logic             fbad;
    logic [MEM_AW-1:0] fidx;

    always_comb
    begin
        req_max    = (size_reg > align_reg) ? size_reg : align_reg;
        req_max_m1 = req_max - 1'b1;
        // ceil(log2(m)) = index of top set bit of m-1, plus one
        ceil_bits = '0;
        for (int i = 0; i < scba_pkg::REQ_W; i++)
        begin
            if (req_max_m1[i])
                ceil_bits = LOG_W'(i + 1);
        end
        req_invalid = (size_reg == '0) ||
                      ((align_reg != '0) && ((align_reg & (align_reg - 1'b1)) != '0));
        too_large = int'(ceil_bits) > MAX_CLASS_BITS;
        if (too_large || int'(ceil_bits) <= MIN_CLASS_BITS)
            alloc_cls = '0;
        else
            alloc_cls = CLS_W'(int'(ceil_bits) - MIN_CLASS_BITS);

        fcls_full = faddr_reg >> PAGE_BITS;
        fcls_ok   = fcls_full < FA_W'(NUM_CLASSES);
        fcls      = fcls_ok ? CLS_W'(fcls_full) : '0;
        foff      = faddr_reg & PAGE_MASK;
        fslot     = foff >> (MIN_CLASS_BITS + int'(fcls));
        // also catches classes whose objects exceed a page (zero slots)
        fbad      = !fcls_ok || (slots_tab[fcls] == '0) ||
                    (CNT_W'(fslot) >= slots_tab[fcls]) ||
                    ((fslot >> CNT_W) != '0);
        fidx      = base_tab[fcls] + MEM_AW'(fslot >> scba_pkg::WORD_SHIFT);
    end

    // ------------------------------------------------------------------
    // Scan and set helpers
    // ------------------------------------------------------------------
    logic [WB-1:0]     rd_word;
    logic [WIDX_W-1:0] nw;
    logic [5:0]        bit_idx;
    logic [ADDR_W-1:0] slot_calc;
    logic [ADDR_W-1:0] obj_calc;

    always_comb
    begin
        rd_word = rd_valid_reg ? rd_data_reg : '0;
        nw      = nw_tab[cls_reg];
        bit_idx = '0;
        for (int i = 0; i < WB; i++)
        begin
            if (onehot_reg[i])
                bit_idx = bit_idx | 6'(i);
        end
        slot_calc = (ADDR_W'(hit_w_reg) << scba_pkg::WORD_SHIFT) | ADDR_W'(bit_idx);
        obj_calc  = (ADDR_W'(cls_reg) << PAGE_BITS) |
                    (slot_calc << (MIN_CLASS_BITS + int'(cls_reg)));
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= scba_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        size_next       = size_reg;
        align_next      = align_reg;
        faddr_next      = faddr_reg;
        cls_next        = cls_reg;
        issue_w_next    = issue_w_reg;
        pend_w_next     = pend_w_reg;
        pend_next       = pend_reg;
        hit_w_next      = hit_w_reg;
        word_next       = word_reg;
        onehot_next     = onehot_reg;
        idx_next        = idx_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_cls_next    = res_cls_reg;
        res_cnt_next    = res_cnt_reg;
        in_stall        = (state_reg != scba_pkg::ST_IDLE);
        out_load        = 1'b0;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = idx_reg;
        mem_wdata       = word_reg | onehot_reg;
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_reg[cls_reg];

        unique case (state_reg)
            scba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    size_next  = request_size;
                    align_next = request_align;
                    faddr_next = free_address;
                    state_next = scba_pkg::ST_DECODE;
                end
            end

            scba_pkg::ST_DECODE:
            begin
                res_addr_next = '0;
                res_cls_next  = '0;
                res_cnt_next  = '0;
                if (op_reg == scba_pkg::OP_ALLOC)
                begin
                    if (req_invalid)
                    begin
                        res_status_next = scba_pkg::STAT_INVALID;
                        state_next      = scba_pkg::ST_OUT;
                    end
                    else if (too_large)
                    begin
                        res_status_next = scba_pkg::STAT_TOO_LARGE;
                        state_next      = scba_pkg::ST_OUT;
                    end
                    else if (cnt_reg[alloc_cls] == '0)
                    begin
                        res_status_next = scba_pkg::STAT_FULL;
                        res_cls_next    = alloc_cls;
                        state_next      = scba_pkg::ST_OUT;
                    end
                    else
                    begin
                        cls_next     = alloc_cls;
                        issue_w_next = '0;
                        pend_next    = 1'b0;
                        state_next   = scba_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    if (fbad)
                    begin
                        res_status_next = scba_pkg::STAT_BAD_ADDR;
                        state_next      = scba_pkg::ST_OUT;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = fidx;
                        idx_next   = fidx;
                        bit_next   = fslot[5:0];
                        cls_next   = fcls;
                        state_next = scba_pkg::ST_FCHK;
                    end
                end
            end

            // one word read issued per cycle, previous word checked
            scba_pkg::ST_SCAN:
            begin
                if (issue_w_reg < nw)
                begin
                    mem_re       = 1'b1;
                    mem_addr     = base_tab[cls_reg] + MEM_AW'(issue_w_reg);
                    issue_w_next = issue_w_reg + WIDX_ONE;
                    pend_w_next  = issue_w_reg;
                    pend_next    = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (!(&rd_word))
                    begin
                        word_next   = rd_word;
                        onehot_next = ~rd_word & (rd_word + 1'b1);
                        idx_next    = base_tab[cls_reg] + MEM_AW'(pend_w_reg);
                        hit_w_next  = pend_w_reg;
                        state_next  = scba_pkg::ST_ASET;
                    end
                    else if (WIDX_W'(pend_w_reg + WIDX_ONE) == nw)
                    begin
                        // bitmap full although the count said otherwise
                        res_status_next = scba_pkg::STAT_FULL;
                        res_addr_next   = '0;
                        res_cls_next    = cls_reg;
                        res_cnt_next    = '0;
                        state_next      = scba_pkg::ST_OUT;
                    end
                end
            end

            scba_pkg::ST_ASET:
            begin
                mem_we          = 1'b1;
                mem_addr        = idx_reg;
                mem_wdata       = word_reg | onehot_reg;
                cnt_we          = 1'b1;
                cnt_wdata       = CNT_W'(cnt_reg[cls_reg] - 1'b1);
                res_status_next = scba_pkg::STAT_OK;
                res_addr_next   = FA_W'(obj_calc);
                res_cls_next    = cls_reg;
                res_cnt_next    = cnt_wdata;
                state_next      = scba_pkg::ST_OUT;
            end

            scba_pkg::ST_FCHK:
            begin
                res_addr_next = '0;
                res_cls_next  = cls_reg;
                if (!rd_word[bit_reg])
                begin
                    res_status_next = scba_pkg::STAT_DOUBLE;
                    res_cnt_next    = cnt_reg[cls_reg];
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_addr        = idx_reg;
                    mem_wdata       = rd_word & ~(WB'(1) << bit_reg);
                    cnt_we          = 1'b1;
                    cnt_wdata       = CNT_W'(cnt_reg[cls_reg] + 1'b1);
                    res_status_next = scba_pkg::STAT_OK;
                    res_cnt_next    = cnt_wdata;
                end
                state_next = scba_pkg::ST_OUT;
            end

            scba_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = scba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = scba_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
                cnt_reg[c] <= CNT_W'(scba_pkg::slots_of(c, PAGE_BITS, MIN_CLASS_BITS));
            for (int w = 0; w < TOTAL_WORDS; w++)
                word_valid_reg[w] <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cnt_we)
                cnt_reg[cls_reg] <= cnt_wdata;
            if (mem_we)
                word_valid_reg[mem_addr] <= 1'b1;
            if (mem_re)
                rd_valid_reg <= word_valid_reg[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Bitmap RAM
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        align_reg      <= align_next;
        faddr_reg      <= faddr_next;
        cls_reg        <= cls_next;
        issue_w_reg    <= issue_w_next;
        pend_w_reg     <= pend_w_next;
        hit_w_reg      <= hit_w_next;
        word_reg       <= word_next;
        onehot_reg     <= onehot_next;
        idx_reg        <= idx_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_cls_reg    <= res_cls_next;
        res_cnt_reg    <= res_cnt_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_cls_reg    <= scba_pkg::SIZE_CLASS_W'(res_cls_reg);
            out_cnt_reg    <= scba_pkg::FREE_CNT_W'(res_cnt_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign object_address   = out_addr_reg;
    assign size_class       = out_cls_reg;
    assign class_free_count = out_cnt_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SCBA_ASSERT_IMP(a_port_exclusive, clk, rst_n, mem_we, !mem_re, "bitmap RAM read and write in one cycle")
    `SCBA_ASSERT_IMP(a_claim_onehot, clk, rst_n, state_reg == scba_pkg::ST_ASET, $onehot(onehot_reg), "claim mask not one-hot")
    `SCBA_ASSERT_IMP(a_claim_count, clk, rst_n, state_reg == scba_pkg::ST_ASET, cnt_reg[cls_reg] != '0, "claim with zero free count")

endmodule
